### design/vmhg_pkg.sv
// ----------------------------------------------------------------------------
// vmhg_pkg
// Shared widths, register indexes, source codes and the configuration bundle
// for the vector magnitude hysteresis gate.
// ----------------------------------------------------------------------------
package vmhg_pkg;

	localparam int AXIS_BITS = 16;
	localparam int IN_W      = 16;
	localparam int SQ_W      = 2 * AXIS_BITS;
	localparam int SUM_W     = SQ_W + 2;
	localparam int THR_W     = 34;
	localparam int CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	typedef enum logic [2:0] {
		REG_SOURCE = 3'd0,
		REG_BELOW  = 3'd1,
		REG_LEVEL  = 3'd2,
		REG_BAND   = 3'd3,
		REG_COUNT  = 3'd4
	} reg_idx_t;

	localparam logic [2:0] SRC_TEMP   = 3'd3;
	localparam logic [2:0] SRC_ALWAYS = 3'd4;

	typedef struct packed {
		logic [2:0]  source_select;
		logic        below_mode;
		logic [15:0] level;
		logic [15:0] band;
		logic [31:0] level_sq;
		logic [33:0] upper_sq;
		logic [31:0] lower_sq;
		logic        lower_ok;
		logic        load;
		logic [15:0] load_value;
	} cfg_t;

endpackage

### design/vmhg_regs.sv
// ----------------------------------------------------------------------------
// vmhg_regs
// APB register file plus registered squared thresholds derived from the
// level and hysteresis band.
// ----------------------------------------------------------------------------
module vmhg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vmhg_pkg::ADDR_W-1:0] paddr,
	input  logic [vmhg_pkg::DATA_W-1:0] pwdata,
	output logic [vmhg_pkg::DATA_W-1:0] prdata,
	output vmhg_pkg::cfg_t             cfg
);
	import vmhg_pkg::*;

	logic [2:0]  source_q;
	logic        below_q;
	logic [15:0] level_q;
	logic [15:0] band_q;
	logic [15:0] count_q;
	logic        load_q;
	logic [31:0] level_sq_q;
	logic [33:0] upper_sq_q;
	logic [31:0] lower_sq_q;
	logic        lower_ok_q;
	logic        wr_en;
	logic [2:0]  idx;
	logic [16:0] upper;
	logic [15:0] lower;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= SRC_ALWAYS;
			below_q  <= 1'b0;
			level_q  <= 16'd0;
			band_q   <= 16'd0;
			count_q  <= 16'd0;
			load_q   <= 1'b0;
		end else begin
			load_q <= 1'b0;
			if (wr_en) begin
				case (idx)
					REG_SOURCE: source_q <= pwdata[2:0];
					REG_BELOW:  below_q  <= pwdata[0];
					REG_LEVEL:  level_q  <= pwdata[15:0];
					REG_BAND:   band_q   <= pwdata[15:0];
					REG_COUNT: begin
						count_q <= pwdata[15:0];
						load_q  <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Squared thresholds are registered from the level and band registers, so they trail the register writes.
	assign upper = {1'b0, level_q} + {1'b0, band_q};
	assign lower = level_q - band_q;

	always_ff @(posedge clk) begin
		level_sq_q <= 32'(level_q) * 32'(level_q);
		upper_sq_q <= 34'(upper) * 34'(upper);
		lower_sq_q <= 32'(lower) * 32'(lower);
		lower_ok_q <= (level_q >= band_q);
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SOURCE: prdata = DATA_W'(source_q);
			REG_BELOW:  prdata = DATA_W'(below_q);
			REG_LEVEL:  prdata = DATA_W'(level_q);
			REG_BAND:   prdata = DATA_W'(band_q);
			REG_COUNT:  prdata = DATA_W'(count_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg = '{
		source_select: source_q,
		below_mode:    below_q,
		level:         level_q,
		band:          band_q,
		level_sq:      level_sq_q,
		upper_sq:      upper_sq_q,
		lower_sq:      lower_sq_q,
		lower_ok:      lower_ok_q,
		load:          load_q,
		load_value:    count_q
	};

endmodule

### design/vmhg_lane.sv
// ----------------------------------------------------------------------------
// vmhg_lane
// One axis lane: absolute value of the reading and its registered square.
// ----------------------------------------------------------------------------
module vmhg_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [vmhg_pkg::IN_W-1:0]  axis,
	output logic [vmhg_pkg::SQ_W-1:0]         sq_s1
);
	import vmhg_pkg::*;

	logic [31:0]          ext;
	logic [AXIS_BITS-1:0] raw;
	logic [AXIS_BITS-1:0] mag;

	assign ext = 32'(axis);
	assign raw = ext[AXIS_BITS-1:0];
	assign mag = raw[AXIS_BITS-1] ? (~raw + AXIS_BITS'(1)) : raw;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= SQ_W'(mag) * SQ_W'(mag);
		end
	end

endmodule

### design/vmhg_merge.sv
// ----------------------------------------------------------------------------
// vmhg_merge
// Sums the lane squares, compares the sum (or the temperature, for the
// temperature source) against the thresholds, runs the hysteresis latch and the
// remaining-sample count, and registers the result.
module vmhg_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic [vmhg_pkg::SQ_W-1:0]  sq_x_s1,
	input  logic [vmhg_pkg::SQ_W-1:0]  sq_y_s1,
	input  logic [vmhg_pkg::SQ_W-1:0]  sq_z_s1,
	input  logic [15:0]                temp_s1,
	input  vmhg_pkg::cfg_t             cfg,
	output logic                       fire_q,
	output logic [15:0]                remain_q,
	output logic                       latch_q
);
	import vmhg_pkg::*;

	logic [CMP_W-1:0] sum;
	logic [CMP_W-1:0] lvl_sq;
	logic [CMP_W-1:0] up_sq;
	logic [CMP_W-1:0] lo_sq;
	logic signed [16:0] diff;
	logic [16:0] adiff;
	logic far, ge, lt, gt, side, back;
	logic fire_d, latch_d;
	logic [15:0] remain_d;
	logic out_fire_q;

	assign sum    = CMP_W'(sq_x_s1) + CMP_W'(sq_y_s1) + CMP_W'(sq_z_s1);
	assign lvl_sq = CMP_W'(cfg.level_sq);
	assign up_sq  = CMP_W'(cfg.upper_sq);
	assign lo_sq  = CMP_W'(cfg.lower_sq);
	assign diff   = $signed({1'b0, temp_s1}) - $signed({1'b0, cfg.level});
	assign adiff  = diff[16] ? 17'(-diff) : 17'(diff);

	always_comb begin
		if (cfg.source_select == SRC_TEMP) begin
			far = adiff >= {1'b0, cfg.band};
			ge  = !diff[16];
			lt  = diff[16];
			gt  = !diff[16] && (diff != 17'sd0);
		end else begin
			far = (cfg.band == 16'd0) || (sum >= up_sq) || (cfg.lower_ok && sum <= lo_sq);
			ge  = sum >= lvl_sq;
			lt  = sum < lvl_sq;
			gt  = sum > lvl_sq;
		end
		side = cfg.below_mode ? lt : ge;
		back = cfg.below_mode ? gt : lt;

		fire_d  = 1'b0;
		latch_d = latch_q;
		if (remain_q != 16'd0) begin
			if (cfg.source_select == SRC_ALWAYS) begin
				fire_d = 1'b1;
			end else if (cfg.source_select <= SRC_TEMP) begin
				if (!far) begin
					// inside the band: rearm
					latch_d = 1'b0;
				end else if (side && !latch_q) begin
					fire_d  = 1'b1;
					latch_d = (cfg.band != 16'd0);
				end else if (latch_q && back) begin
					latch_d = 1'b0;
				end
			end
		end
		remain_d = fire_d ? (remain_q - 16'd1) : remain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q   <= 16'd0;
			latch_q    <= 1'b0;
			out_fire_q <= 1'b0;
		end else if (cfg.load) begin
			remain_q <= cfg.load_value;
		end else if (upd) begin
			remain_q   <= remain_d;
			latch_q    <= latch_d;
			out_fire_q <= fire_d;
		end
	end

	assign fire_q = out_fire_q;

endmodule

### design/vector_magnitude_hysteresis_gate_unit.sv
// ----------------------------------------------------------------------------
// vector_magnitude_hysteresis_gate_unit
// Pipeline: lane squares register at request accept; the merge compare and
// state update land in the output register when it is free or draining.
// Throughput: one request per cycle unless out_ready holds the output back;
// the latch/count update loops within the merge stage. Reset: registers to
// defaults (source 4, rest 0), count 0, latch clear, pipeline empty.
// ----------------------------------------------------------------------------
module vector_magnitude_hysteresis_gate_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [vmhg_pkg::ADDR_W-1:0]       paddr,
	input  logic [vmhg_pkg::DATA_W-1:0]       pwdata,
	output logic [vmhg_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [vmhg_pkg::IN_W-1:0]  axis_x,
	input  logic signed [vmhg_pkg::IN_W-1:0]  axis_y,
	input  logic signed [vmhg_pkg::IN_W-1:0]  axis_z,
	input  logic [15:0]                       temperature,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              take_sample,
	output logic [15:0]                       samples_left,
	output logic                              latch_set
);
	import vmhg_pkg::*;

	cfg_t            cfg;
	logic            s1_valid_q;
	logic            out_valid_q;
	logic            s1_adv;
	logic            in_acc;
	logic [SQ_W-1:0] sq_x_s1, sq_y_s1, sq_z_s1;
	logic [15:0]     temp_s1;

	assign pready = 1'b1;

	vmhg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite && pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// advance stage 1 into the output register when it is free or draining
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) s1_valid_q <= in_valid;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) temp_s1 <= temperature;
	end

	vmhg_lane u_lane_x (.clk(clk), .en(in_acc), .axis(axis_x), .sq_s1(sq_x_s1));
	vmhg_lane u_lane_y (.clk(clk), .en(in_acc), .axis(axis_y), .sq_s1(sq_y_s1));
	vmhg_lane u_lane_z (.clk(clk), .en(in_acc), .axis(axis_z), .sq_s1(sq_z_s1));

	vmhg_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (s1_adv),
		.sq_x_s1  (sq_x_s1),
		.sq_y_s1  (sq_y_s1),
		.sq_z_s1  (sq_z_s1),
		.temp_s1  (temp_s1),
		.cfg      (cfg),
		.fire_q   (take_sample),
		.remain_q (samples_left),
		.latch_q  (latch_set)
	);

	assign out_valid = out_valid_q;

endmodule
